// ===== rtl/dual_trie_word_classifier_unit_assert.svh =====
// assertion macros used by the classifier rtl
`ifndef DUAL_TRIE_WORD_CLASSIFIER_UNIT_ASSERT_SVH
`define DUAL_TRIE_WORD_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DTWC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dtwc assertion failed");
`define DTWC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dtwc assertion failed");
`else
`define DTWC_ASSERT_SAME(name, ante, cons)
`define DTWC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== rtl/dtwc_pkg.sv =====
// shared constants, codes and types of the dual trie word classifier
package dtwc_pkg;

    localparam int unsigned TRIE_NODES = 65536;
    localparam int unsigned MAX_WORD   = 30;
    localparam int unsigned KEY_SPACE  = 64;
    localparam int unsigned LETTERS    = 26;

    localparam int unsigned NODE_W   = 16;
    localparam int unsigned LETTER_W = 5;
    localparam int unsigned KEY_W    = 6;
    localparam int unsigned CNT_W    = 5;

    localparam int unsigned CHILD_W     = NODE_W + 1;
    localparam int unsigned CHILD_DEPTH = TRIE_NODES * LETTERS;
    localparam int unsigned CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int unsigned ENDS_AW     = $clog2(TRIE_NODES);
    localparam int unsigned KEY_AW      = $clog2(KEY_SPACE);

    localparam logic [LETTER_W-1:0] NON_LETTER = LETTER_W'(31);
    localparam logic [CNT_W-1:0]    CNT_MAX    = {CNT_W{1'b1}};

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned RESULT_W    = 1 + 3 + CNT_W;
    localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int unsigned CFG_IDX_W   = 1;

    typedef enum logic [1:0] {
        FUNC_CHILD = 2'd0,
        FUNC_END   = 2'd1,
        FUNC_MAP   = 2'd2,
        FUNC_KEY   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        VERDICT_FOUND        = 3'd0,
        VERDICT_NOT_LOADED   = 3'd1,
        VERDICT_BAD_LENGTH   = 3'd2,
        VERDICT_NON_LETTER   = 3'd3,
        VERDICT_IN_SECONDARY = 3'd4,
        VERDICT_NOT_FOUND    = 3'd5
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIMARY_LOADED   = 1'b0,
        CFG_SECONDARY_LOADED = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        func_t               func;
        logic                which_trie;
        logic [NODE_W-1:0]   node_index;
        logic [LETTER_W-1:0] letter;
        logic [NODE_W-1:0]   child_index;
        logic                child_present;
        logic                end_mark;
        logic [KEY_W-1:0]    key_code;
        logic [LETTER_W-1:0] map_letter;
        logic                last_key;
    } item_t;

    typedef struct packed {
        item_t               item;
        logic [LETTER_W-1:0] key_letter;
        logic                non_letter;
    } step_t;

    typedef struct packed {
        logic             p_dead;
        logic             s_dead;
        logic             saw_non_letter;
        logic [CNT_W-1:0] key_count;
    } tally_t;

    typedef struct packed {
        logic [CNT_W-1:0] word_length;
        verdict_t         verdict;
        logic             is_primary_word;
    } result_t;

endpackage

// ===== rtl/dtwc_ram.sv =====
// generic single write port ram with registered read
module dtwc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dtwc_keymap.sv =====
// input stage with the key code to letter map
module dtwc_keymap (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  dtwc_pkg::item_t in_item,
    output logic           s1_valid,
    output dtwc_pkg::step_t s1_step,
    input  logic           s1_take
);
    import dtwc_pkg::*;

    logic                s1_valid_reg;
    item_t               s1_item_reg;
    logic                s1_hit_reg;
    logic [KEY_SPACE-1:0] map_valid_reg;
    logic                in_accept;
    logic                key_ok;
    logic [KEY_AW-1:0]   key_addr;
    logic                map_we;
    logic                map_re;
    logic [LETTER_W-1:0] map_q;
    logic [LETTER_W-1:0] key_letter;

    assign in_ready  = !s1_valid_reg || s1_take;
    assign in_accept = in_valid && in_ready;
    assign key_ok    = 32'(in_item.key_code) < KEY_SPACE;
    assign key_addr  = KEY_AW'(in_item.key_code);
    assign map_we    = in_accept && (in_item.func == FUNC_MAP) && key_ok;
    assign map_re    = in_accept && (in_item.func == FUNC_KEY);

    dtwc_ram #(
        .WIDTH(LETTER_W),
        .DEPTH(KEY_SPACE)
    ) u_key_map (
        .aclk (aclk),
        .we   (map_we),
        .waddr(key_addr),
        .wdata(in_item.map_letter),
        .re   (map_re),
        .raddr(key_addr),
        .rdata(map_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            map_valid_reg <= '0;
        end else begin
            if (map_we) begin
                map_valid_reg[key_addr] <= 1'b1;
            end
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_take) begin
                s1_valid_reg <= 1'b0;
            end
        end
        if (in_accept) begin
            s1_item_reg <= in_item;
            s1_hit_reg  <= key_ok && map_valid_reg[key_addr];
        end
    end

    // unmapped or out-of-range keys read as non-letter
    assign key_letter         = s1_hit_reg ? map_q : NON_LETTER;
    assign s1_valid           = s1_valid_reg;
    assign s1_step.item       = s1_item_reg;
    assign s1_step.key_letter = key_letter;
    assign s1_step.non_letter = 32'(key_letter) >= LETTERS;

endmodule

// ===== rtl/dtwc_walk.sv =====
// trie tables and the two walks over them
`include "dual_trie_word_classifier_unit_assert.svh"

module dtwc_walk (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s1_valid,
    input  dtwc_pkg::step_t s1_step,
    output logic            s1_take,
    output logic            s3_valid,
    output dtwc_pkg::tally_t s3_tally,
    output logic            p_end,
    output logic            s_end,
    input  logic            s3_ready
);
    import dtwc_pkg::*;

    logic                s2_valid_reg;
    logic                s2_last_reg;
    logic                s2_non_letter_reg;
    logic                s3_valid_reg;
    tally_t              s3_tally_reg;
    logic [NODE_W-1:0]   p_cursor_reg;
    logic [NODE_W-1:0]   s_cursor_reg;
    logic                p_dead_reg;
    logic                s_dead_reg;
    logic                saw_non_letter_reg;
    logic [CNT_W-1:0]    key_count_reg;

    logic [NODE_W-1:0]   p_cursor_next;
    logic [NODE_W-1:0]   s_cursor_next;
    logic                p_dead_next;
    logic                s_dead_next;
    logic                saw_non_letter_next;
    logic [CNT_W-1:0]    key_count_next;

    logic                s1_is_key;
    logic                s3_free;
    logic                s2_move;
    logic                node_ok;
    logic                child_ok;
    logic                child_re;
    logic                p_child_we;
    logic                s_child_we;
    logic                p_ends_we;
    logic                s_ends_we;
    logic                ends_re;
    logic [CHILD_AW-1:0] child_waddr;
    logic [CHILD_AW-1:0] p_child_raddr;
    logic [CHILD_AW-1:0] s_child_raddr;
    logic [CHILD_W-1:0]  child_wdata;
    logic [CHILD_W-1:0]  p_child_q;
    logic [CHILD_W-1:0]  s_child_q;
    logic [ENDS_AW-1:0]  ends_waddr;

    assign s1_is_key = s1_step.item.func == FUNC_KEY;
    assign s3_free   = !s3_valid_reg || s3_ready;
    assign s2_move   = s2_valid_reg && (!s2_last_reg || s3_free);
    // a key waits until the previous key has settled the cursors
    // a table write waits while a finished word still has to read its end marks
    assign s1_take   = s1_valid && (s1_is_key ? !s2_valid_reg
                                              : !(s2_valid_reg && s2_last_reg));

    assign node_ok  = 32'(s1_step.item.node_index) < TRIE_NODES;
    assign child_ok = node_ok && (32'(s1_step.item.letter) < LETTERS);

    assign p_child_we = s1_take && (s1_step.item.func == FUNC_CHILD) && child_ok
                        && !s1_step.item.which_trie;
    assign s_child_we = s1_take && (s1_step.item.func == FUNC_CHILD) && child_ok
                        && s1_step.item.which_trie;
    assign p_ends_we  = s1_take && (s1_step.item.func == FUNC_END) && node_ok
                        && !s1_step.item.which_trie;
    assign s_ends_we  = s1_take && (s1_step.item.func == FUNC_END) && node_ok
                        && s1_step.item.which_trie;
    assign child_re   = s1_take && s1_is_key && !s1_step.non_letter;
    assign ends_re    = s2_move && s2_last_reg;

    assign child_waddr   = CHILD_AW'(32'(s1_step.item.node_index) * LETTERS
                                     + 32'(s1_step.item.letter));
    assign p_child_raddr = CHILD_AW'(32'(p_cursor_reg) * LETTERS
                                     + 32'(s1_step.key_letter));
    assign s_child_raddr = CHILD_AW'(32'(s_cursor_reg) * LETTERS
                                     + 32'(s1_step.key_letter));
    assign child_wdata   = {s1_step.item.child_present, s1_step.item.child_index};
    assign ends_waddr    = ENDS_AW'(s1_step.item.node_index);

    dtwc_ram #(
        .WIDTH(CHILD_W),
        .DEPTH(CHILD_DEPTH)
    ) u_primary_children (
        .aclk (aclk),
        .we   (p_child_we),
        .waddr(child_waddr),
        .wdata(child_wdata),
        .re   (child_re),
        .raddr(p_child_raddr),
        .rdata(p_child_q)
    );

    dtwc_ram #(
        .WIDTH(CHILD_W),
        .DEPTH(CHILD_DEPTH)
    ) u_secondary_children (
        .aclk (aclk),
        .we   (s_child_we),
        .waddr(child_waddr),
        .wdata(child_wdata),
        .re   (child_re),
        .raddr(s_child_raddr),
        .rdata(s_child_q)
    );

    dtwc_ram #(
        .WIDTH(1),
        .DEPTH(TRIE_NODES)
    ) u_primary_ends (
        .aclk (aclk),
        .we   (p_ends_we),
        .waddr(ends_waddr),
        .wdata(s1_step.item.end_mark),
        .re   (ends_re),
        .raddr(ENDS_AW'(p_cursor_next)),
        .rdata(p_end)
    );

    dtwc_ram #(
        .WIDTH(1),
        .DEPTH(TRIE_NODES)
    ) u_secondary_ends (
        .aclk (aclk),
        .we   (s_ends_we),
        .waddr(ends_waddr),
        .wdata(s1_step.item.end_mark),
        .re   (ends_re),
        .raddr(ENDS_AW'(s_cursor_next)),
        .rdata(s_end)
    );

    always_comb begin
        p_dead_next = p_dead_reg || s2_non_letter_reg || !p_child_q[NODE_W]
                      || (32'(p_child_q[NODE_W-1:0]) >= TRIE_NODES);
        s_dead_next = s_dead_reg || s2_non_letter_reg || !s_child_q[NODE_W]
                      || (32'(s_child_q[NODE_W-1:0]) >= TRIE_NODES);
        p_cursor_next = p_dead_next ? p_cursor_reg : p_child_q[NODE_W-1:0];
        s_cursor_next = s_dead_next ? s_cursor_reg : s_child_q[NODE_W-1:0];
        saw_non_letter_next = saw_non_letter_reg || s2_non_letter_reg;
        key_count_next = (key_count_reg == CNT_MAX) ? key_count_reg
                                                    : key_count_reg + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg       <= 1'b0;
            s3_valid_reg       <= 1'b0;
            p_cursor_reg       <= '0;
            s_cursor_reg       <= '0;
            p_dead_reg         <= 1'b0;
            s_dead_reg         <= 1'b0;
            saw_non_letter_reg <= 1'b0;
            key_count_reg      <= '0;
        end else begin
            if (s1_take && s1_is_key) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_move) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move && s2_last_reg) begin
                s3_valid_reg       <= 1'b1;
                p_cursor_reg       <= '0;
                s_cursor_reg       <= '0;
                p_dead_reg         <= 1'b0;
                s_dead_reg         <= 1'b0;
                saw_non_letter_reg <= 1'b0;
                key_count_reg      <= '0;
            end else begin
                if (s3_ready) begin
                    s3_valid_reg <= 1'b0;
                end
                if (s2_move) begin
                    p_cursor_reg       <= p_cursor_next;
                    s_cursor_reg       <= s_cursor_next;
                    p_dead_reg         <= p_dead_next;
                    s_dead_reg         <= s_dead_next;
                    saw_non_letter_reg <= saw_non_letter_next;
                    key_count_reg      <= key_count_next;
                end
            end
        end
        if (s1_take && s1_is_key) begin
            s2_last_reg       <= s1_step.item.last_key;
            s2_non_letter_reg <= s1_step.non_letter;
        end
        if (s2_move && s2_last_reg) begin
            s3_tally_reg.p_dead         <= p_dead_next;
            s3_tally_reg.s_dead         <= s_dead_next;
            s3_tally_reg.saw_non_letter <= saw_non_letter_next;
            s3_tally_reg.key_count      <= key_count_next;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3_tally = s3_tally_reg;

    `DTWC_ASSERT_SAME(a_key_interlock, s1_take && s1_is_key, !s2_valid_reg)
    `DTWC_ASSERT_SAME(a_child_port_split, p_child_we || s_child_we, !child_re)
    `DTWC_ASSERT_NEXT(a_word_restart, s2_move && s2_last_reg, key_count_reg == '0 && !saw_non_letter_reg && !p_dead_reg && p_cursor_reg == '0)
    `DTWC_ASSERT_NEXT(a_tally_hold, s3_valid_reg && !s3_ready, s3_valid_reg && $stable(s3_tally_reg))

endmodule

// ===== rtl/dtwc_judge.sv =====
// verdict priority and result register
module dtwc_judge (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  primary_loaded,
    input  logic                                  secondary_loaded,
    input  logic                                  s3_valid,
    input  dtwc_pkg::tally_t                      s3_tally,
    input  logic                                  p_end,
    input  logic                                  s_end,
    output logic                                  s3_ready,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dtwc_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import dtwc_pkg::*;

    logic     out_valid_reg;
    result_t  out_result_reg;
    result_t  result;
    verdict_t verdict;

    assign s3_ready = !out_valid_reg || m_tready;

    always_comb begin
        if (!primary_loaded) begin
            verdict = VERDICT_NOT_LOADED;
        end else if ((32'(s3_tally.key_count) < 2) || (32'(s3_tally.key_count) > MAX_WORD)) begin
            verdict = VERDICT_BAD_LENGTH;
        end else if (s3_tally.saw_non_letter) begin
            verdict = VERDICT_NON_LETTER;
        end else if (secondary_loaded && !s3_tally.s_dead && s_end) begin
            verdict = VERDICT_IN_SECONDARY;
        end else if (!s3_tally.p_dead && p_end) begin
            verdict = VERDICT_FOUND;
        end else begin
            verdict = VERDICT_NOT_FOUND;
        end
        result.word_length     = s3_tally.key_count;
        result.verdict         = verdict;
        result.is_primary_word = verdict == VERDICT_FOUND;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s3_valid && s3_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (s3_valid && s3_ready) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_result_reg};

endmodule

// ===== rtl/dual_trie_word_classifier_unit.sv =====
// Dual trie word classifier. Table writes (child pointer, end mark)
// wait while the last key of a word still has to read its end marks; a key of
// a word waits for the previous key to leave the walk stage, set by the loop
// from the cursor registers through the child memories' registered read back
// into the next key's child address. The verdict of a word passes the child
// read, the end-mark read and the result register, and is held back while the
// result side is stalled.
// Child and end-mark memories are not cleared and must be written before a
// walk reaches them; the key map starts as non-letter for every code.
module dual_trie_word_classifier_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // node_index, letter, child_index, child_present, end_mark, key_code,
    // map_letter, zero pad
    input  logic [dtwc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // func, which_trie
    input  logic [dtwc_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // is_primary_word, verdict, word_length, zero pad
    output logic [dtwc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dtwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic                                 cfg_data
);
    import dtwc_pkg::*;

    logic   primary_loaded_reg;
    logic   secondary_loaded_reg;
    item_t  in_item;
    logic   s1_valid;
    step_t  s1_step;
    logic   s1_take;
    logic   s3_valid;
    tally_t s3_tally;
    logic   s3_ready;
    logic   p_end;
    logic   s_end;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primary_loaded_reg   <= 1'b0;
            secondary_loaded_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRIMARY_LOADED: begin
                    primary_loaded_reg <= cfg_data;
                end
                CFG_SECONDARY_LOADED: begin
                    secondary_loaded_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_item.func          = func_t'(s_tuser[1:0]);
        in_item.which_trie    = s_tuser[2];
        in_item.node_index    = s_tdata[15:0];
        in_item.letter        = s_tdata[20:16];
        in_item.child_index   = s_tdata[36:21];
        in_item.child_present = s_tdata[37];
        in_item.end_mark      = s_tdata[38];
        in_item.key_code      = s_tdata[44:39];
        in_item.map_letter    = s_tdata[49:45];
        in_item.last_key      = s_tlast;
    end

    dtwc_keymap u_keymap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_item (in_item),
        .s1_valid(s1_valid),
        .s1_step (s1_step),
        .s1_take (s1_take)
    );

    dtwc_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s1_valid(s1_valid),
        .s1_step (s1_step),
        .s1_take (s1_take),
        .s3_valid(s3_valid),
        .s3_tally(s3_tally),
        .p_end   (p_end),
        .s_end   (s_end),
        .s3_ready(s3_ready)
    );

    dtwc_judge u_judge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .primary_loaded  (primary_loaded_reg),
        .secondary_loaded(secondary_loaded_reg),
        .s3_valid        (s3_valid),
        .s3_tally        (s3_tally),
        .p_end           (p_end),
        .s_end           (s_end),
        .s3_ready        (s3_ready),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

// ===== tb/dual_trie_word_classifier_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the dual trie word classifier unit
module dual_trie_word_classifier_unit_test;
    import dtwc_pkg::*;

    localparam int unsigned LIVE_NODES    = 10;
    localparam int unsigned REACH_NODES   = 8;
    localparam int unsigned ITEM_TARGET   = 1850;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASES        = 6;
    // {secondary_loaded, primary_loaded} per random phase
    localparam bit [1:0] PHASE_FLAGS [PHASES] = '{2'b11, 2'b01, 2'b10, 2'b11, 2'b00, 2'b11};

    class word_verdict_board;
        bit [CHILD_W-1:0]  child_tab [int unsigned];
        bit                end_tab [int unsigned];
        bit [LETTER_W-1:0] key_map [KEY_SPACE];
        bit [NODE_W-1:0]   cursor [2];
        bit                dead [2];
        bit                saw_non_letter;
        bit [CNT_W-1:0]    key_count;
        bit                primary_loaded;
        bit                secondary_loaded;
        result_t           pending_verdicts [$];
        int unsigned       errors;

        function new();
            foreach (key_map[k]) key_map[k] = NON_LETTER;
            primary_loaded = 1'b0;
            secondary_loaded = 1'b0;
            errors = 0;
            restart_word();
        endfunction

        function void restart_word();
            cursor[0] = '0;
            cursor[1] = '0;
            dead[0] = 1'b0;
            dead[1] = 1'b0;
            saw_non_letter = 1'b0;
            key_count = '0;
        endfunction

        function int unsigned slot_key(int unsigned t, int unsigned node, int unsigned lt);
            return (t * TRIE_NODES + node) * LETTERS + lt;
        endfunction

        function bit [CHILD_W-1:0] child_slot(int unsigned t, int unsigned node,
                                              int unsigned lt);
            int unsigned k;
            k = slot_key(t, node, lt);
            return child_tab.exists(k) ? child_tab[k] : '0;
        endfunction

        function bit ends_here(int unsigned t);
            int unsigned k;
            k = t * TRIE_NODES + cursor[t];
            if (dead[t] || !end_tab.exists(k)) return 1'b0;
            return end_tab[k];
        endfunction

        function void set_loaded(cfg_idx_t idx, logic value);
            if (idx == CFG_PRIMARY_LOADED) primary_loaded = value;
            else secondary_loaded = value;
        endfunction

        function void note_item(item_t it);
            bit [LETTER_W-1:0] got;
            bit [CHILD_W-1:0]  slot;
            result_t           want;
            int unsigned       t;
            case (it.func)
                FUNC_CHILD: begin
                    if (it.letter < LETTERS)
                        child_tab[slot_key(it.which_trie, it.node_index, it.letter)] =
                            {it.child_present, it.child_index};
                end
                FUNC_END: begin
                    end_tab[it.which_trie * TRIE_NODES + it.node_index] = it.end_mark;
                end
                FUNC_MAP: begin
                    key_map[it.key_code] = it.map_letter;
                end
                default: begin
                    if (key_count != CNT_MAX) key_count++;
                    got = key_map[it.key_code];
                    if (got >= LETTERS) begin
                        saw_non_letter = 1'b1;
                        dead[0] = 1'b1;
                        dead[1] = 1'b1;
                    end else begin
                        for (t = 0; t < 2; t++) begin
                            if (!dead[t]) begin
                                slot = child_slot(t, cursor[t], got);
                                if (!slot[NODE_W]) dead[t] = 1'b1;
                                else cursor[t] = slot[NODE_W-1:0];
                            end
                        end
                    end
                    if (it.last_key) begin
                        if (!primary_loaded) want.verdict = VERDICT_NOT_LOADED;
                        else if (key_count < 2 || key_count > MAX_WORD)
                            want.verdict = VERDICT_BAD_LENGTH;
                        else if (saw_non_letter) want.verdict = VERDICT_NON_LETTER;
                        else if (secondary_loaded && ends_here(1))
                            want.verdict = VERDICT_IN_SECONDARY;
                        else if (ends_here(0)) want.verdict = VERDICT_FOUND;
                        else want.verdict = VERDICT_NOT_FOUND;
                        want.is_primary_word = (want.verdict == VERDICT_FOUND);
                        want.word_length = key_count;
                        pending_verdicts.push_back(want);
                        restart_word();
                    end
                end
            endcase
        endfunction

        function void check_verdict(logic [OUT_TDATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[RESULT_W-1:0]);
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: verdict %0d word_length %0d",
                       got.verdict, got.word_length);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.is_primary_word !== want.is_primary_word) begin
                $error("is_primary_word expected %0d got %0d",
                       want.is_primary_word, got.is_primary_word);
                errors++;
            end
            if (got.verdict !== want.verdict) begin
                $error("verdict expected %0d got %0d", want.verdict, got.verdict);
                errors++;
            end
            if (got.word_length !== want.word_length) begin
                $error("word_length expected %0d got %0d", want.word_length, got.word_length);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic                   cfg_data;

    word_verdict_board sb;
    int unsigned       items_sent;
    int unsigned       cycle_count;
    bit                in_burst;

    dual_trie_word_classifier_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic item_t noise_item();
        item_t it;
        it.func          = func_t'(2'($urandom_range(0, 3)));
        it.which_trie    = 1'($urandom_range(0, 1));
        it.node_index    = NODE_W'($urandom_range(0, 16'hFFFF));
        it.letter        = LETTER_W'($urandom_range(0, 31));
        it.child_index   = NODE_W'($urandom_range(0, 16'hFFFF));
        it.child_present = 1'($urandom_range(0, 1));
        it.end_mark      = 1'($urandom_range(0, 1));
        it.key_code      = KEY_W'($urandom_range(0, KEY_SPACE - 1));
        it.map_letter    = LETTER_W'($urandom_range(0, 31));
        it.last_key      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // most trie writes stay in the live region so every walk reads written entries
    function automatic item_t table_item();
        item_t it;
        it = noise_item();
        it.func = func_t'(2'($urandom_range(0, 2)));
        if ($urandom_range(0, 4) != 0) it.node_index = NODE_W'($urandom_range(0, LIVE_NODES - 1));
        if ($urandom_range(0, 9) == 0) it.letter = LETTER_W'($urandom_range(LETTERS, 31));
        else it.letter = LETTER_W'($urandom_range(0, LETTERS - 1));
        if (it.child_present && it.node_index < LIVE_NODES)
            it.child_index = NODE_W'($urandom_range(0, REACH_NODES - 1));
        if ($urandom_range(0, 9) < 7) it.map_letter = LETTER_W'($urandom_range(0, LETTERS - 1));
        return it;
    endfunction

    function automatic item_t child_write(input logic t, input logic [NODE_W-1:0] node,
                                          input logic [LETTER_W-1:0] lt,
                                          input logic [NODE_W-1:0] child, input logic present);
        item_t it;
        it = noise_item();
        it.func = FUNC_CHILD;
        it.which_trie = t;
        it.node_index = node;
        it.letter = lt;
        it.child_index = child;
        it.child_present = present;
        return it;
    endfunction

    function automatic item_t end_write(input logic t, input logic [NODE_W-1:0] node,
                                        input logic mark);
        item_t it;
        it = noise_item();
        it.func = FUNC_END;
        it.which_trie = t;
        it.node_index = node;
        it.end_mark = mark;
        return it;
    endfunction

    function automatic item_t map_write(input logic [KEY_W-1:0] code,
                                        input logic [LETTER_W-1:0] lt);
        item_t it;
        it = noise_item();
        it.func = FUNC_MAP;
        it.key_code = code;
        it.map_letter = lt;
        return it;
    endfunction

    function automatic item_t key_item(input logic [KEY_W-1:0] code, input logic last);
        item_t it;
        it = noise_item();
        it.func = FUNC_KEY;
        it.key_code = code;
        it.last_key = last;
        return it;
    endfunction

    // key whose letter continues the current walk of trie t, when there is one
    function automatic logic [KEY_W-1:0] trail_key(input int unsigned t);
        int unsigned       opts [$];
        int unsigned       base;
        int unsigned       k;
        int unsigned       l;
        bit [CHILD_W-1:0]  slot;
        if (sb.dead[t]) return KEY_W'($urandom_range(0, KEY_SPACE - 1));
        for (l = 0; l < LETTERS; l++) begin
            slot = sb.child_slot(t, sb.cursor[t], l);
            if (slot[NODE_W]) opts.push_back(l);
        end
        if (opts.size() == 0) return KEY_W'($urandom_range(0, KEY_SPACE - 1));
        l = opts[$urandom_range(0, opts.size() - 1)];
        base = $urandom_range(0, KEY_SPACE - 1);
        for (k = 0; k < KEY_SPACE; k++) begin
            if (sb.key_map[(base + k) % KEY_SPACE] == l) return KEY_W'((base + k) % KEY_SPACE);
        end
        return KEY_W'($urandom_range(0, KEY_SPACE - 1));
    endfunction

    task automatic send(input item_t it);
        int unsigned gap;
        gap = in_burst ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {it.which_trie, it.func};
        s_tlast  <= it.last_key;
        s_tdata  <= {6'd0, it.map_letter, it.key_code, it.end_mark, it.child_present,
                     it.child_index, it.letter, it.node_index};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_item(it);
        items_sent++;
    endtask

    // follow: 0 random keys, 1 walk the primary trie, 2 walk the secondary trie
    task automatic send_word(input int unsigned len, input int unsigned follow);
        int unsigned       i;
        logic [KEY_W-1:0]  code;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 24) == 0) send(table_item());
            if (follow != 0 && $urandom_range(0, 29) != 0) code = trail_key(follow - 1);
            else code = KEY_W'($urandom_range(0, KEY_SPACE - 1));
            send(key_item(code, i == len - 1));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_flags(input logic primary, input logic secondary);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PRIMARY_LOADED;
        cfg_data  <= primary;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.set_loaded(CFG_PRIMARY_LOADED, primary);
        cfg_index <= CFG_SECONDARY_LOADED;
        cfg_data  <= secondary;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.set_loaded(CFG_SECONDARY_LOADED, secondary);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_verdict(m_tdata);
    end

    initial begin
        int unsigned stall;
        bit          fast;
        fast = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0) fast = !fast;
            stall = fast ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
        end
    end

    initial begin
        int unsigned t;
        int unsigned n;
        int unsigned l;
        int unsigned k;
        int unsigned p;
        int unsigned goal;
        int unsigned pick;
        int unsigned lsel;
        int unsigned len;
        logic        present;

        sb = new();
        items_sent = 0;
        in_burst   = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PRIMARY_LOADED;
        cfg_data  <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every slot and end mark of the live nodes in both tries
        for (t = 0; t < 2; t++) begin
            for (n = 0; n < LIVE_NODES; n++) begin
                for (l = 0; l < LETTERS; l++) begin
                    present = ($urandom_range(0, 99) < 45);
                    send(child_write(1'(t), NODE_W'(n), LETTER_W'(l),
                                     present ? NODE_W'($urandom_range(0, REACH_NODES - 1))
                                             : NODE_W'($urandom_range(0, 16'hFFFF)),
                                     present));
                end
                send(end_write(1'(t), NODE_W'(n), 1'($urandom_range(0, 1))));
            end
        end

        // known paths: ab ends in primary, cd ends in both, ac dies in primary
        send(child_write(1'b0, 16'd0, 5'd0, 16'd1, 1'b1));
        send(child_write(1'b0, 16'd1, 5'd1, 16'd2, 1'b1));
        send(end_write(1'b0, 16'd2, 1'b1));
        send(child_write(1'b0, 16'd1, 5'd2, 16'hFFFF, 1'b0));
        send(child_write(1'b0, 16'd0, 5'd2, 16'd3, 1'b1));
        send(child_write(1'b0, 16'd3, 5'd3, 16'd4, 1'b1));
        send(end_write(1'b0, 16'd4, 1'b1));
        send(child_write(1'b1, 16'd0, 5'd2, 16'd3, 1'b1));
        send(child_write(1'b1, 16'd3, 5'd3, 16'd4, 1'b1));
        send(end_write(1'b1, 16'd4, 1'b1));
        send(child_write(1'b1, 16'hFFFF, 5'd25, 16'hFFFF, 1'b1));
        send(end_write(1'b1, 16'hFFFF, 1'b1));
        send(child_write(1'b0, 16'd0, 5'd31, 16'hFFFF, 1'b1));

        // key map still all non-letter and nothing loaded
        send(key_item(6'd0, 1'b1));

        for (k = 0; k < KEY_SPACE; k++)
            send(map_write(KEY_W'(k), (k < 52) ? LETTER_W'(k % 26) : LETTER_W'(26 + k % 6)));

        drain();
        load_flags(1'b1, 1'b0);
        send(key_item(6'd0, 1'b1));
        send(key_item(6'd0, 1'b0));
        send(key_item(6'd1, 1'b1));
        send(key_item(6'd2, 1'b0));
        send(key_item(6'd3, 1'b1));
        send(key_item(6'd0, 1'b0));
        send(key_item(6'd63, 1'b1));
        send(key_item(6'd0, 1'b0));
        send(key_item(6'd2, 1'b1));
        send(key_item(6'd60, 1'b1));

        drain();
        load_flags(1'b1, 1'b1);
        send(key_item(6'd2, 1'b0));
        send(key_item(6'd3, 1'b1));
        send(key_item(6'd0, 1'b0));
        send(key_item(6'd1, 1'b1));
        send(key_item(6'd2, 1'b0));
        send(end_write(1'b1, 16'd4, 1'b0));
        send(key_item(6'd3, 1'b1));

        for (p = 0; p < PHASES; p++) begin
            drain();
            load_flags(PHASE_FLAGS[p][0], PHASE_FLAGS[p][1]);
            goal = items_sent + (ITEM_TARGET > items_sent ?
                                 (ITEM_TARGET - items_sent) / (PHASES - p) : 0);
            while (items_sent < goal) begin
                if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
                pick = $urandom_range(0, 99);
                if (pick == 0) begin
                    drain();
                end else if (pick < 20) begin
                    repeat ($urandom_range(1, 3)) send(table_item());
                end else begin
                    lsel = $urandom_range(0, 9);
                    if (lsel == 0) len = 1;
                    else if (lsel < 8) len = $urandom_range(2, 6);
                    else if (lsel == 8) len = $urandom_range(7, 12);
                    else len = $urandom_range(28, 34);
                    send_word(len, $urandom_range(0, 2));
                end
            end
        end

        drain();
        if (sb.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
